// ----- hw/rtl/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the three-wire register serial master
// Request payloads, classified queue items, configuration bundle and codes.
// ----------------------------------------------------------------------------
package tws_pkg;

	// operation codes of a request
	typedef enum logic [1:0] {
		OP_TICK,
		OP_WRITE,
		OP_READ,
		OP_FREQ
	} op_t;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TXW,
		PH_TXR,
		PH_TURN,
		PH_RX,
		PH_GAP
	} phase_t;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FREQ_MIN = 2'd0;
	localparam logic [1:0] CFG_FREQ_MAX = 2'd1;
	localparam logic [1:0] CFG_HALF_PER = 2'd2;

	// configuration reset values
	localparam logic [19:0] FREQ_MIN_RST = 20'd50000;
	localparam logic [19:0] FREQ_MAX_RST = 20'd1000000;
	localparam logic [7:0]  HALF_PER_RST = 8'd1;

	// frame constants
	localparam logic [6:0] ADDR_FREQ_HI    = 7'h29;
	localparam logic [6:0] ADDR_FREQ_LO    = 7'h2A;
	localparam logic [4:0] WRITE_BITS      = 5'd24;
	localparam logic [4:0] READ_CMD_BITS   = 5'd8;
	localparam logic [4:0] READ_DATA_BITS  = 5'd16;

	// input request fields
	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  cmd_code;
		logic [15:0] write_data;
		logic [19:0] freq_req;
		logic        sda_in;
	} tws_in_t;

	// result fields
	typedef struct packed {
		logic        chip_select_n;
		logic        serial_clock;
		logic        serial_data_out;
		logic        data_drive_enable;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  status;
		logic [7:0]  read_low;
		logic [7:0]  read_high;
	} tws_out_t;

	// request after classification
	typedef struct packed {
		op_t         op;
		logic [7:0]  cmd_code;
		logic [15:0] write_data;
		logic        sda_in;
		logic        freq_ok;
		logic [15:0] freq_hi;
		logic [15:0] freq_lo;
	} tws_item_t;

	// configuration bundle
	typedef struct packed {
		logic [19:0] freq_min;
		logic [19:0] freq_max;
		logic [7:0]  half_period;
	} tws_cfg_t;

endpackage

// ----- hw/rtl/tws_front.sv -----
// ----------------------------------------------------------------------------
// tws_front: request intake and classification
// Decodes each request, checks the frequency range, splits the scaled
// frequency into its two register words and holds items in a 2-entry queue.
// ----------------------------------------------------------------------------
module tws_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tws_pkg::tws_in_t   in_data,
	input  tws_pkg::tws_cfg_t  cfg,
	output logic               q_valid,
	output tws_pkg::tws_item_t q_item,
	input  logic               q_pop
);

	tws_pkg::tws_item_t item_c;
	tws_pkg::tws_item_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push;

	// classify: range check and freq * 16 split into bits 23:16 and 15:0
	always_comb begin
		item_c.op           = tws_pkg::op_t'(in_data.operation);
		item_c.cmd_code     = in_data.cmd_code;
		item_c.write_data   = in_data.write_data;
		item_c.sda_in       = in_data.sda_in;
		item_c.freq_ok      = (in_data.freq_req >= cfg.freq_min) &&
		                      (in_data.freq_req <= cfg.freq_max);
		item_c.freq_hi      = {8'd0, in_data.freq_req[19:12]};
		item_c.freq_lo      = {in_data.freq_req[11:0], 4'd0};
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_c;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef SYNTH
	// pop only what is stored
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
`endif

endmodule

// ----- hw/rtl/tws_back.sv -----
// ----------------------------------------------------------------------------
// tws_back: serial sequencer
// Runs one tick of pin timing per queued item and registers the pin levels
// and status of that tick in the result register.
// ----------------------------------------------------------------------------
module tws_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tws_pkg::tws_item_t q_item,
	output logic               q_pop,
	input  tws_pkg::tws_cfg_t  cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output tws_pkg::tws_out_t  out_data
);

	tws_pkg::phase_t   phase_q, n_phase;
	logic [4:0]        bc_q, n_bc;
	logic [7:0]        pt_q, n_pt;
	logic [23:0]       tx_q, n_tx;
	logic [15:0]       rx_q, n_rx;
	logic [15:0]       pend_lo_q, n_pend_lo;
	logic              pend_q, n_pend;
	logic              lvl_q, n_lvl;
	logic              done_c;
	logic [1:0]        status_c;
	tws_pkg::tws_out_t res_c;
	tws_pkg::tws_out_t out_data_q;
	logic              out_valid_q;
	logic [7:0]        hp;
	logic [7:0]        pt_inc;
	logic [7:0]        tk_pt;
	logic              tk_lvl;
	logic [4:0]        tk_bc;
	logic              tk_bit;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// clock phase advance for this tick
	always_comb begin
		hp     = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
		pt_inc = pt_q + 8'd1;
		tk_pt  = pt_inc;
		tk_lvl = lvl_q;
		tk_bc  = bc_q;
		tk_bit = 1'b0;
		if (pt_inc >= hp) begin
			tk_pt = 8'd0;
			if (!lvl_q) begin
				tk_lvl = 1'b1;
			end else begin
				tk_lvl = 1'b0;
				tk_bc  = bc_q - 5'd1;
				tk_bit = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		n_phase   = phase_q;
		n_bc      = bc_q;
		n_pt      = pt_q;
		n_tx      = tx_q;
		n_rx      = rx_q;
		n_pend_lo = pend_lo_q;
		n_pend    = pend_q;
		n_lvl     = lvl_q;
		done_c    = 1'b0;
		status_c  = tws_pkg::ST_OK;
		unique case (phase_q)
			tws_pkg::PH_IDLE: begin
				unique case (q_item.op)
					tws_pkg::OP_TICK: begin
					end
					tws_pkg::OP_WRITE: begin
						n_pend  = 1'b0;
						n_phase = tws_pkg::PH_TXW;
						n_tx    = {1'b0, q_item.cmd_code[6:0], q_item.write_data};
						n_bc    = tws_pkg::WRITE_BITS;
						n_pt    = 8'd0;
						n_lvl   = 1'b0;
					end
					tws_pkg::OP_READ: begin
						n_pend  = 1'b0;
						n_rx    = 16'd0;
						n_phase = tws_pkg::PH_TXR;
						n_tx    = {q_item.cmd_code, 16'd0};
						n_bc    = tws_pkg::READ_CMD_BITS;
						n_pt    = 8'd0;
						n_lvl   = 1'b0;
					end
					tws_pkg::OP_FREQ: begin
						if (!q_item.freq_ok) begin
							done_c   = 1'b1;
							status_c = tws_pkg::ST_RANGE;
						end else begin
							n_pend_lo = q_item.freq_lo;
							n_pend    = 1'b1;
							n_phase   = tws_pkg::PH_TXW;
							n_tx      = {1'b0, tws_pkg::ADDR_FREQ_HI, q_item.freq_hi};
							n_bc      = tws_pkg::WRITE_BITS;
							n_pt      = 8'd0;
							n_lvl     = 1'b0;
						end
					end
				endcase
			end
			tws_pkg::PH_TXW, tws_pkg::PH_TXR: begin
				n_pt  = tk_pt;
				n_lvl = tk_lvl;
				n_bc  = tk_bc;
				if (tk_bit) begin
					n_tx = {tx_q[22:0], 1'b0};
					if (tk_bc == 5'd0) begin
						if (phase_q == tws_pkg::PH_TXR) begin
							n_phase = tws_pkg::PH_TURN;
						end else if (pend_q) begin
							n_phase = tws_pkg::PH_GAP;
						end else begin
							n_phase = tws_pkg::PH_IDLE;
							done_c  = 1'b1;
						end
					end
				end
			end
			tws_pkg::PH_TURN: begin
				n_phase = tws_pkg::PH_RX;
				n_tx    = 24'd0;
				n_bc    = tws_pkg::READ_DATA_BITS;
				n_pt    = 8'd0;
				n_lvl   = 1'b0;
			end
			tws_pkg::PH_RX: begin
				n_pt  = tk_pt;
				n_lvl = tk_lvl;
				n_bc  = tk_bc;
				if (tk_bit && (tk_bc == 5'd0)) begin
					n_phase = tws_pkg::PH_IDLE;
					done_c  = 1'b1;
				end else if (tk_lvl && (tk_pt == hp - 8'd1)) begin
					// sample on the last tick of the high phase
					n_rx = {rx_q[14:0], q_item.sda_in};
				end
			end
			tws_pkg::PH_GAP: begin
				n_pend  = 1'b0;
				n_phase = tws_pkg::PH_TXW;
				n_tx    = {1'b0, tws_pkg::ADDR_FREQ_LO, pend_lo_q};
				n_bc    = tws_pkg::WRITE_BITS;
				n_pt    = 8'd0;
				n_lvl   = 1'b0;
			end
			default: begin
				n_phase = tws_pkg::PH_IDLE;
			end
		endcase
		// a request during a transfer is refused, the transfer goes on
		if ((phase_q != tws_pkg::PH_IDLE) && (q_item.op != tws_pkg::OP_TICK)) begin
			done_c   = 1'b1;
			status_c = tws_pkg::ST_BUSY;
		end
	end

	// pin levels and status of this tick
	always_comb begin
		res_c.chip_select_n     = (n_phase == tws_pkg::PH_IDLE) ||
		                          (n_phase == tws_pkg::PH_GAP);
		res_c.serial_clock      = ((n_phase == tws_pkg::PH_TXW) ||
		                           (n_phase == tws_pkg::PH_TXR) ||
		                           (n_phase == tws_pkg::PH_RX)) && n_lvl;
		res_c.data_drive_enable = !((n_phase == tws_pkg::PH_TURN) ||
		                            (n_phase == tws_pkg::PH_RX));
		res_c.serial_data_out   = ((n_phase == tws_pkg::PH_TXW) ||
		                           (n_phase == tws_pkg::PH_TXR)) && n_tx[23];
		res_c.busy_res          = (n_phase != tws_pkg::PH_IDLE);
		res_c.done_res          = done_c;
		res_c.status            = status_c;
		res_c.read_low          = n_rx[15:8];
		res_c.read_high         = n_rx[7:0];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tws_pkg::PH_IDLE;
			bc_q      <= 5'd0;
			pt_q      <= 8'd0;
			tx_q      <= 24'd0;
			rx_q      <= 16'd0;
			pend_lo_q <= 16'd0;
			pend_q    <= 1'b0;
			lvl_q     <= 1'b0;
		end else if (q_pop) begin
			phase_q   <= n_phase;
			bc_q      <= n_bc;
			pt_q      <= n_pt;
			tx_q      <= n_tx;
			rx_q      <= n_rx;
			pend_lo_q <= n_pend_lo;
			pend_q    <= n_pend;
			lvl_q     <= n_lvl;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= res_c;
		end
	end

`ifndef SYNTH
	// the gap only exists while the second frequency write is owed
	a_gap_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == tws_pkg::PH_GAP) |-> pend_q)
		else $error("gap phase without pending write");

	// clock rests low when idle
	a_idle_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == tws_pkg::PH_IDLE) |-> !lvl_q)
		else $error("clock high in idle");

	// bit counter never exceeds a full write frame
	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= tws_pkg::WRITE_BITS)
		else $error("bit counter out of range");
`endif

endmodule

// ----- hw/rtl/three_wire_register_serial_master.sv -----
// An accepted request passes the queue and then the result register before out_valid
// rises; while the output stalls, requests wait in the queue and the result register.
// Throughput: one request per cycle unless the output stalls; the sequencer steps one
// tick per cycle to the result register; a 2-entry queue decouples intake from stalls.
// Reset: arst_n clears the queue, sequencer and result valid; configuration returns
// to 50000 / 1000000 kHz and a half period of 1 tick.
// ----------------------------------------------------------------------------
// three_wire_register_serial_master: tick-driven 3-wire serial register master
// Holds the configuration registers and joins the intake queue to the sequencer.
// ----------------------------------------------------------------------------
module three_wire_register_serial_master (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tws_pkg::tws_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tws_pkg::tws_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [19:0]       cfg_wdata
);

	tws_pkg::tws_cfg_t  cfg_q;
	logic               q_valid;
	logic               q_pop;
	tws_pkg::tws_item_t q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq_min    <= tws_pkg::FREQ_MIN_RST;
			cfg_q.freq_max    <= tws_pkg::FREQ_MAX_RST;
			cfg_q.half_period <= tws_pkg::HALF_PER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tws_pkg::CFG_FREQ_MIN: cfg_q.freq_min    <= cfg_wdata;
				tws_pkg::CFG_FREQ_MAX: cfg_q.freq_max    <= cfg_wdata;
				tws_pkg::CFG_HALF_PER: cfg_q.half_period <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	tws_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	tws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
